// File: sv/crcfr_pkg.sv
// crcfr_pkg: shared constants, register indexes, control/status structs and
// the crc-16/modbus byte update for the frame receiver
// no dependencies
`timescale 1ns / 1ps

package crcfr_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SOF_FIRST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOF_SECOND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd4;

  localparam logic [7:0]  RST_SOF_FIRST    = 8'd170;
  localparam logic [7:0]  RST_SOF_SECOND   = 8'd85;
  localparam logic [7:0]  RST_VERSION      = 8'd1;
  localparam logic [6:0]  RST_MAX_LEN      = 7'd64;
  localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd100;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [7:0]  sof_first;
    logic [7:0]  sof_second;
    logic [7:0]  version;
    logic [6:0]  max_len;
    logic [15:0] idle_timeout;
  } cfg_t;

  typedef struct packed {
    logic idle_clr;
    logic idle_inc;
    logic clear;
    logic crc_init;
    logic crc_upd;
    logic ld_type;
    logic ld_lenl;
    logic ld_seq;
    logic wr_data;
    logic ld_crcl;
    logic emit_start;
    logic emit_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_sof_first;
    logic is_sof_second;
    logic ver_ok;
    logic len_bad;
    logic len_zero;
    logic data_done;
    logic crc_ok;
    logic timeout_hit;
    logic emit_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/crcfr_in_if.sv
// crcfr_in_if: input channel carrying received bytes and millisecond ticks
// no dependencies
`timescale 1ns / 1ps

interface crcfr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

// File: sv/crcfr_out_if.sv
// crcfr_out_if: result channel carrying validated frame payload bytes
// no dependencies
`timescale 1ns / 1ps

interface crcfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_type;
  logic [7:0] seq_num;
  logic [6:0] payload_len;
  logic       has_data;
  logic [7:0] data_byte;
  logic [5:0] byte_index;
  logic       last;

  modport source (output valid, output msg_type, output seq_num, output payload_len,
                  output has_data, output data_byte, output byte_index, output last,
                  input ready);
  modport sink (input valid, input msg_type, input seq_num, input payload_len,
                input has_data, input data_byte, input byte_index, input last,
                output ready);
endinterface

// File: sv/crcfr_cfg.sv
// crcfr_cfg: configuration register file written through a plain write port
// depends on crcfr_pkg
`timescale 1ns / 1ps

module crcfr_cfg import crcfr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SOF_FIRST:    cfg_d.sof_first    = cfg_data_i[7:0];
        REG_SOF_SECOND:   cfg_d.sof_second   = cfg_data_i[7:0];
        REG_VERSION:      cfg_d.version      = cfg_data_i[7:0];
        REG_MAX_LEN:      cfg_d.max_len      = cfg_data_i[6:0];
        REG_IDLE_TIMEOUT: cfg_d.idle_timeout = cfg_data_i[15:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sof_first    <= RST_SOF_FIRST;
      cfg_q.sof_second   <= RST_SOF_SECOND;
      cfg_q.version      <= RST_VERSION;
      cfg_q.max_len      <= RST_MAX_LEN;
      cfg_q.idle_timeout <= RST_IDLE_TIMEOUT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/crcfr_ctrl.sv
// crcfr_ctrl: frame parsing state machine, drives the datapath by commands
// depends on crcfr_pkg
`timescale 1ns / 1ps

module crcfr_ctrl import crcfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_cmd_i,
  output logic       in_ready_o,
  input  dp_status_t st_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [3:0] PH_SOF0 = 4'd0;
  localparam logic [3:0] PH_SOF1 = 4'd1;
  localparam logic [3:0] PH_VER  = 4'd2;
  localparam logic [3:0] PH_TYPE = 4'd3;
  localparam logic [3:0] PH_LENL = 4'd4;
  localparam logic [3:0] PH_LENH = 4'd5;
  localparam logic [3:0] PH_SEQ  = 4'd6;
  localparam logic [3:0] PH_DATA = 4'd7;
  localparam logic [3:0] PH_CRCL = 4'd8;
  localparam logic [3:0] PH_CRCH = 4'd9;
  localparam logic [3:0] PH_EMIT = 4'd10;

  logic [3:0] phase_q, phase_d;
  logic       acc;

  assign in_ready_o = (phase_q != PH_EMIT);
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    phase_d = phase_q;
    cmd_o   = '0;
    if (phase_q == PH_EMIT) begin
      if (st_i.out_free) begin
        cmd_o.emit_load = 1'b1;
        if (st_i.emit_last) begin
          cmd_o.clear = 1'b1;
          phase_d     = PH_SOF0;
        end
      end
    end else if (acc && in_cmd_i == CMD_TICK) begin
      cmd_o.idle_inc = 1'b1;
      if (phase_q != PH_SOF0 && st_i.timeout_hit) begin
        cmd_o.clear = 1'b1;
        phase_d     = PH_SOF0;
      end
    end else if (acc) begin
      cmd_o.idle_clr = 1'b1;
      case (phase_q)
        PH_SOF0: begin
          if (st_i.is_sof_first) phase_d = PH_SOF1;
        end
        PH_SOF1: begin
          if (st_i.is_sof_second) begin
            phase_d = PH_VER;
          end else if (!st_i.is_sof_first) begin
            cmd_o.clear = 1'b1;
            phase_d     = PH_SOF0;
          end
        end
        PH_VER: begin
          if (st_i.ver_ok) begin
            cmd_o.crc_init = 1'b1;
            phase_d        = PH_TYPE;
          end else begin
            cmd_o.clear = 1'b1;
            phase_d     = PH_SOF0;
          end
        end
        PH_TYPE: begin
          cmd_o.ld_type = 1'b1;
          cmd_o.crc_upd = 1'b1;
          phase_d       = PH_LENL;
        end
        PH_LENL: begin
          cmd_o.ld_lenl = 1'b1;
          cmd_o.crc_upd = 1'b1;
          phase_d       = PH_LENH;
        end
        PH_LENH: begin
          if (st_i.len_bad) begin
            cmd_o.clear = 1'b1;
            phase_d     = PH_SOF0;
          end else begin
            cmd_o.crc_upd = 1'b1;
            phase_d       = PH_SEQ;
          end
        end
        PH_SEQ: begin
          cmd_o.ld_seq  = 1'b1;
          cmd_o.crc_upd = 1'b1;
          phase_d       = st_i.len_zero ? PH_CRCL : PH_DATA;
        end
        PH_DATA: begin
          cmd_o.wr_data = 1'b1;
          cmd_o.crc_upd = 1'b1;
          if (st_i.data_done) phase_d = PH_CRCL;
        end
        PH_CRCL: begin
          cmd_o.ld_crcl = 1'b1;
          phase_d       = PH_CRCH;
        end
        PH_CRCH: begin
          if (st_i.crc_ok) begin
            cmd_o.emit_start = 1'b1;
            phase_d          = PH_EMIT;
          end else begin
            cmd_o.clear = 1'b1;
            phase_d     = PH_SOF0;
          end
        end
        default: begin
          cmd_o.clear = 1'b1;
          phase_d     = PH_SOF0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SOF0;
    end else begin
      phase_q <= phase_d;
    end
  end

  a_last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_load && st_i.emit_last |=> phase_q == PH_SOF0)
    else $error("emission did not end after last result");

  a_emit_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_start |=> phase_q == PH_EMIT && !in_ready_o)
    else $error("good crc did not start emission");

endmodule

// File: sv/crcfr_dp.sv
// crcfr_dp: crc, header fields, payload memory, idle counter and result register
// depends on crcfr_pkg
`timescale 1ns / 1ps

module crcfr_dp import crcfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic [7:0]  rx_byte_i,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  st_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  msg_type_o,
  output logic [7:0]  seq_num_o,
  output logic [6:0]  payload_len_o,
  output logic        has_data_o,
  output logic [7:0]  data_byte_o,
  output logic [5:0]  byte_index_o,
  output logic        last_o
);

  logic [15:0]      crc_q, crc_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       lenl_q, lenl_d;
  logic [7:0]       seq_q, seq_d;
  logic [7:0]       crcl_q, crcl_d;
  logic [CNT_W-1:0] taken_q, taken_d;
  logic [15:0]      idle_q, idle_d;
  logic [15:0]      idle_nxt;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]       rd_q;
  logic [7:0]       mem [MAX_PAYLOAD];
  logic [6:0]       limit;
  logic [CNT_W-1:0] taken_inc;
  logic             has_data;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       o_type_q, o_seq_q, o_data_q;
  logic [6:0]       o_len_q;
  logic             o_has_q, o_last_q;
  logic [5:0]       o_idx_q;

  assign limit     = (cfg_i.max_len > 7'(MAX_PAYLOAD)) ? 7'(MAX_PAYLOAD) : cfg_i.max_len;
  assign taken_inc = taken_q + 1'b1;
  assign idle_nxt  = (idle_q == TICK_MAX) ? idle_q : idle_q + 16'd1;
  assign has_data  = (lenl_q != 8'd0);

  always_comb begin
    st_o.is_sof_first  = (rx_byte_i == cfg_i.sof_first);
    st_o.is_sof_second = (rx_byte_i == cfg_i.sof_second);
    st_o.ver_ok        = (rx_byte_i == cfg_i.version);
    st_o.len_bad       = (rx_byte_i != 8'd0) || (lenl_q > {1'b0, limit});
    st_o.len_zero      = !has_data;
    st_o.data_done     = ({1'b0, taken_inc} >= lenl_q);
    st_o.crc_ok        = ({rx_byte_i, crcl_q} == crc_q);
    st_o.timeout_hit   = (idle_nxt > cfg_i.idle_timeout);
    st_o.emit_last     = !has_data || ((idx_q + 1'b1) == lenl_q[CNT_W-1:0]);
    st_o.out_free      = !out_valid_q || out_ready_i;
  end

  always_comb begin
    crc_d   = crc_q;
    type_d  = type_q;
    lenl_d  = lenl_q;
    seq_d   = seq_q;
    crcl_d  = crcl_q;
    taken_d = taken_q;
    if (cmd_i.crc_init) crc_d = crc_add(CRC_INIT, rx_byte_i);
    if (cmd_i.crc_upd)  crc_d = crc_add(crc_q, rx_byte_i);
    if (cmd_i.ld_type)  type_d = rx_byte_i;
    if (cmd_i.ld_lenl)  lenl_d = rx_byte_i;
    if (cmd_i.ld_seq) begin
      seq_d   = rx_byte_i;
      taken_d = '0;
    end
    if (cmd_i.wr_data)  taken_d = taken_inc;
    if (cmd_i.ld_crcl)  crcl_d = rx_byte_i;
    if (cmd_i.clear) begin
      crc_d   = '0;
      type_d  = '0;
      lenl_d  = '0;
      seq_d   = '0;
      crcl_d  = '0;
      taken_d = '0;
    end
  end

  always_comb begin
    idle_d = idle_q;
    if (cmd_i.idle_clr) idle_d = '0;
    if (cmd_i.idle_inc) idle_d = idle_nxt;
  end

  // read address tracks the next emit index so rd_q always matches idx_q
  always_comb begin
    idx_d   = idx_q;
    rd_addr = idx_q[ADDR_W-1:0];
    if (cmd_i.emit_start) begin
      idx_d   = '0;
      rd_addr = '0;
    end else if (cmd_i.emit_load) begin
      idx_d   = idx_q + 1'b1;
      rd_addr = idx_d[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_data) mem[taken_q[ADDR_W-1:0]] <= rx_byte_i;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= '0;
      type_q  <= '0;
      lenl_q  <= '0;
      seq_q   <= '0;
      crcl_q  <= '0;
      taken_q <= '0;
      idle_q  <= '0;
      idx_q   <= '0;
    end else begin
      crc_q   <= crc_d;
      type_q  <= type_d;
      lenl_q  <= lenl_d;
      seq_q   <= seq_d;
      crcl_q  <= crcl_d;
      taken_q <= taken_d;
      idle_q  <= idle_d;
      idx_q   <= idx_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.emit_load)            out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      o_type_q <= type_q;
      o_seq_q  <= seq_q;
      o_len_q  <= lenl_q[6:0];
      o_has_q  <= has_data;
      o_data_q <= has_data ? rd_q : 8'd0;
      o_idx_q  <= has_data ? idx_q[ADDR_W-1:0] : 6'd0;
      o_last_q <= st_o.emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign msg_type_o    = o_type_q;
  assign seq_num_o     = o_seq_q;
  assign payload_len_o = o_len_q;
  assign has_data_o    = o_has_q;
  assign data_byte_o   = o_data_q;
  assign byte_index_o  = o_idx_q;
  assign last_o        = o_last_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_data |-> {1'b0, taken_q} < lenl_q)
    else $error("payload write beyond frame length");

  a_idle_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.idle_clr |=> idle_q == 16'd0)
    else $error("idle counter not cleared by a byte");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_load |-> (idx_q < lenl_q[CNT_W-1:0]) || (!has_data && idx_q == '0))
    else $error("emit index outside payload");

endmodule

// File: sv/crc16_frame_receiver_top.sv
// crc16_frame_receiver_top: a byte or tick transfer is taken while the parser is not emitting
// a good frame's crc high byte transfer sets the emit phase, which loads the first result
// into the result register, then one per cycle while the sink keeps up, from a registered
// payload memory read; input is held off during emission, which loads each payload byte,
// or one result for an empty frame, and waits while the sink leaves the result register full
// reset clears the parser, idle counter, result valid and config to defaults; no memory reset
`timescale 1ns / 1ps

module crc16_frame_receiver_top import crcfr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  crcfr_in_if.sink              in_if,
  crcfr_out_if.source           out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t st;

  crcfr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  crcfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_cmd_i   (in_if.cmd),
    .in_ready_o (in_if.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  crcfr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .rx_byte_i     (in_if.rx_byte),
    .cmd_i         (cmd),
    .st_o          (st),
    .out_ready_i   (out_if.ready),
    .out_valid_o   (out_if.valid),
    .msg_type_o    (out_if.msg_type),
    .seq_num_o     (out_if.seq_num),
    .payload_len_o (out_if.payload_len),
    .has_data_o    (out_if.has_data),
    .data_byte_o   (out_if.data_byte),
    .byte_index_o  (out_if.byte_index),
    .last_o        (out_if.last)
  );

endmodule
